[rtl/assert_macros.svh]
// Assertion macros shared by the bus decoder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/abd_pkg.sv]
// Shared types and constants of the arcade board bus decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package abd_pkg;

  localparam int COLOR_W = 24;

  // Bus cycle kinds.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_ACK   = 2'd3;

  // Result targets.
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_MAIN = 2'd1;
  localparam logic [1:0] TGT_ROM  = 2'd2;
  localparam logic [1:0] TGT_INT  = 2'd3;

  // Tile layers.
  localparam logic [1:0] LYR_NONE = 2'd0;
  localparam logic [1:0] LYR_TEXT = 2'd1;
  localparam logic [1:0] LYR_FG   = 2'd2;
  localparam logic [1:0] LYR_BG   = 2'd3;

  // Scroll layers.
  localparam logic [1:0] SCR_NONE = 2'd0;
  localparam logic [1:0] SCR_FG   = 2'd1;
  localparam logic [1:0] SCR_BG   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FRAME_PERIOD = 2'd0;
  localparam logic [1:0] CFG_BLANK_LENGTH = 2'd1;
  localparam logic [1:0] CFG_SCROLL_BIAS  = 2'd2;
  localparam logic [1:0] CFG_DIP_HIGH     = 2'd3;

  // Reset values.
  localparam logic [17:0] FRAME_PERIOD_RST = 18'd66666;
  localparam logic [12:0] BLANK_LENGTH_RST = 13'd5292;
  localparam logic [7:0]  SCROLL_BIAS_RST  = 8'd48;
  localparam logic [7:0]  DIP_HIGH_RST     = 8'd8;

  // Address map.
  localparam logic [15:0] ADDR_RAM_LO  = 16'hc000;
  localparam logic [15:0] ADDR_MAIN_HI = 16'hefff;
  localparam logic [15:0] ADDR_TXT_LO  = 16'hd000;
  localparam logic [15:0] ADDR_TXT_HI  = 16'hd7ff;
  localparam logic [15:0] ADDR_FG_LO   = 16'hd800;
  localparam logic [15:0] ADDR_FG_HI   = 16'hdbff;
  localparam logic [15:0] ADDR_BG_LO   = 16'hdc00;
  localparam logic [15:0] ADDR_BG_HI   = 16'hdfff;
  localparam logic [15:0] ADDR_PAL_LO  = 16'he800;
  localparam logic [15:0] ADDR_ROM_LO  = 16'hf000;
  localparam logic [15:0] ADDR_ROM_HI  = 16'hf7ff;
  localparam logic [15:0] ADDR_FGS_LO  = 16'hf800;
  localparam logic [15:0] ADDR_FGS_HI  = 16'hf802;
  localparam logic [15:0] ADDR_BGS_LO  = 16'hf803;
  localparam logic [15:0] ADDR_BGS_HI  = 16'hf805;
  localparam logic [15:0] ADDR_BANK    = 16'hf808;
  localparam logic [15:0] ADDR_JOY     = 16'hf800;
  localparam logic [15:0] ADDR_BTN     = 16'hf801;
  localparam logic [15:0] ADDR_SYS     = 16'hf804;
  localparam logic [15:0] ADDR_DIP     = 16'hf809;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // Decoded bus cycle waiting for its colour cache data.
  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  target;
    logic [15:0] maddr;
    logic        mwrite;
    logic [1:0]  dirty_layer;
    logic [9:0]  dirty_index;
    logic        pal_wr;
    logic [9:0]  pal_idx;
    logic        pal_odd;
    logic [7:0]  pal_data;
    logic [1:0]  scroll_layer;
    logic [16:0] scroll_x;
    logic        irq;
  } stage_t;

endpackage
`default_nettype wire

[rtl/arcade_board_bus_decoder.sv]
// Bus decoder and frame timer: each transaction is registered in the cache read stage and
// then in the output registers, one transaction per cycle unless out_stall or the cache
// clear stalls the input; the colour cache read-modify-write is split over the read
// cycle and the write-back cycle, with forwarding. Reset (rst_n, synchronous) restores
// the registers and timers, then a clearing pass zeroes the colour cache while input is stalled.
`default_nettype none
`include "assert_macros.svh"
module arcade_board_bus_decoder #(
  parameter int PALETTE_ENTRIES = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_mode,
  input  wire  [15:0] in_address,
  input  wire  [7:0]  in_write_data,
  input  wire  [5:0]  in_tick_count,
  input  wire  [7:0]  in_joystick_bits,
  input  wire  [7:0]  in_button_bits,
  input  wire  [7:0]  in_system_bits,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_read_data,
  output logic [1:0]  out_target,
  output logic [15:0] out_memory_address,
  output logic        out_memory_write,
  output logic [1:0]  out_dirty_layer,
  output logic [9:0]  out_dirty_index,
  output logic        out_palette_write,
  output logic [9:0]  out_palette_index,
  output logic [31:0] out_palette_color,
  output logic [1:0]  out_scroll_layer,
  output logic [16:0] out_scroll_x,
  output logic        out_interrupt,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [17:0] cfg_data
);
  import abd_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [12:0] PE13 = 13'(PALETTE_ENTRIES);

  // Configuration registers.
  logic [17:0] frame_period_r;
  logic [12:0] blank_length_r;
  logic [7:0]  scroll_bias_r;
  logic [7:0]  dip_high_r;

  // Timer and decoder state.
  logic [18:0]        frame_cnt_r, frame_cnt_nxt;
  logic signed [13:0] blank_cnt_r, blank_cnt_nxt;
  logic [4:0]         rom_bank_r, rom_bank_nxt;
  logic [7:0]         fg0_r, fg1_r, bg0_r, bg1_r;
  logic [7:0]         fg0_nxt, fg1_nxt, bg0_nxt, bg1_nxt;

  // Pipeline.
  stage_t             s0;
  stage_t             s1_r;
  logic               s1_v_r;
  logic               s1_adv;
  logic               in_accept;
  logic               fwd_r;
  logic [COLOR_W-1:0] fwd_data_r;
  logic               out_valid_r;

  logic [COLOR_W-1:0] cache_rdata;
  logic [COLOR_W-1:0] base_c;
  logic [COLOR_W-1:0] new_c;
  logic               cache_busy;

  // Output payload registers.
  logic [7:0]  read_data_r;
  logic [1:0]  target_r;
  logic [15:0] maddr_r;
  logic        mwrite_r;
  logic [1:0]  dirty_layer_r;
  logic [9:0]  dirty_index_r;
  logic        pal_wr_r;
  logic [9:0]  pal_idx_r;
  logic [31:0] pal_color_r;
  logic [1:0]  scroll_layer_r;
  logic [16:0] scroll_x_r;
  logic        irq_r;

  assign s1_adv    = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall  = cache_busy || (s1_v_r && !s1_adv);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_period_r <= FRAME_PERIOD_RST;
      blank_length_r <= BLANK_LENGTH_RST;
      scroll_bias_r  <= SCROLL_BIAS_RST;
      dip_high_r     <= DIP_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_PERIOD: frame_period_r <= cfg_data;
        CFG_BLANK_LENGTH: blank_length_r <= cfg_data[12:0];
        CFG_SCROLL_BIAS:  scroll_bias_r  <= cfg_data[7:0];
        CFG_DIP_HIGH:     dip_high_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Frame timer and blanking countdown, then the address decode.
  always_comb begin
    logic signed [19:0] fc_sub;
    logic signed [19:0] fc_add;
    logic signed [13:0] bc_cur;
    logic               wrap;
    logic               irq;
    logic [9:0]         pv;
    logic [2:0]         bsel;

    fc_sub = $signed({1'b0, frame_cnt_r}) - $signed({14'd0, in_tick_count});
    fc_add = fc_sub + $signed({2'b0, frame_period_r});
    wrap   = (fc_sub <= 20'sd0);
    if (!wrap) begin
      frame_cnt_nxt = fc_sub[18:0];
    end else if (fc_add < 20'sd0) begin
      frame_cnt_nxt = '0;
    end else begin
      frame_cnt_nxt = fc_add[18:0];
    end
    bc_cur = wrap ? $signed({1'b0, blank_length_r}) : blank_cnt_r;
    if (bc_cur > 14'sd0) begin
      blank_cnt_nxt = bc_cur - $signed({8'd0, in_tick_count});
      irq = 1'b1;
    end else begin
      blank_cnt_nxt = '0;
      irq = 1'b0;
    end

    rom_bank_nxt = rom_bank_r;
    fg0_nxt = fg0_r;
    fg1_nxt = fg1_r;
    bg0_nxt = bg0_r;
    bg1_nxt = bg1_r;
    s0 = '0;
    s0.pal_data = in_write_data;
    s0.pal_odd  = in_address[0];

    // Colour cache index: half the window offset, wrapped to the cache size.
    pv = in_address[10:1];
    for (int k = 0; k < 3; k++) begin
      if ({3'b0, pv} >= PE13) begin
        pv = pv - PE13[9:0];
      end
    end
    s0.pal_idx = pv;
    bsel = in_address[2:0] - 3'd3;

    unique case (in_mode)
      MODE_WRITE: begin
        if (in_address >= ADDR_RAM_LO && in_address <= ADDR_MAIN_HI) begin
          s0.target = TGT_MAIN;
          s0.maddr  = in_address;
          s0.mwrite = 1'b1;
          if (in_address >= ADDR_TXT_LO && in_address <= ADDR_TXT_HI) begin
            s0.dirty_layer = LYR_TEXT;
            s0.dirty_index = in_address[9:0];
          end else if (in_address >= ADDR_FG_LO && in_address <= ADDR_FG_HI) begin
            s0.dirty_layer = LYR_FG;
            s0.dirty_index = {1'b0, in_address[8:0]};
          end else if (in_address >= ADDR_BG_LO && in_address <= ADDR_BG_HI) begin
            s0.dirty_layer = LYR_BG;
            s0.dirty_index = {1'b0, in_address[8:0]};
          end else if (in_address >= ADDR_PAL_LO) begin
            s0.pal_wr = 1'b1;
          end
        end else if (in_address >= ADDR_FGS_LO && in_address <= ADDR_FGS_HI) begin
          // The third scroll byte is never reported, so it is not kept.
          if (in_address[1:0] == 2'd0) fg0_nxt = in_write_data;
          if (in_address[1:0] == 2'd1) fg1_nxt = in_write_data;
          s0.scroll_layer = SCR_FG;
          s0.scroll_x = {1'b0, fg1_nxt, fg0_nxt} + {9'd0, scroll_bias_r};
        end else if (in_address >= ADDR_BGS_LO && in_address <= ADDR_BGS_HI) begin
          if (bsel == 3'd0) bg0_nxt = in_write_data;
          if (bsel == 3'd1) bg1_nxt = in_write_data;
          s0.scroll_layer = SCR_BG;
          s0.scroll_x = {1'b0, bg1_nxt, bg0_nxt} + {9'd0, scroll_bias_r};
        end else if (in_address == ADDR_BANK) begin
          rom_bank_nxt = in_write_data[7:3];
        end
      end
      MODE_READ: begin
        if (in_address <= ADDR_MAIN_HI) begin
          s0.target = TGT_MAIN;
          s0.maddr  = in_address;
        end else if (in_address >= ADDR_ROM_LO && in_address <= ADDR_ROM_HI) begin
          s0.target = TGT_ROM;
          s0.maddr  = {rom_bank_r, in_address[10:0]};
        end else begin
          s0.target = TGT_INT;
          if (in_address == ADDR_JOY) begin
            s0.read_data = in_joystick_bits;
          end else if (in_address == ADDR_BTN) begin
            s0.read_data = in_button_bits;
          end else if (in_address == ADDR_SYS) begin
            s0.read_data = in_system_bits;
          end else if (in_address == ADDR_DIP) begin
            s0.read_data = dip_high_r;
          end
        end
      end
      MODE_ACK:  irq = 1'b0;
      MODE_IDLE: ;
      default: ;
    endcase
    s0.irq = irq;
    // Items that do not touch the colour cache must not look like cache writes.
    s0.pal_idx = s0.pal_wr ? s0.pal_idx : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= {1'b0, FRAME_PERIOD_RST};
      blank_cnt_r <= '0;
      rom_bank_r  <= '0;
      fg0_r       <= '0;
      fg1_r       <= '0;
      bg0_r       <= '0;
      bg1_r       <= '0;
    end else if (in_accept) begin
      frame_cnt_r <= frame_cnt_nxt;
      blank_cnt_r <= blank_cnt_nxt;
      rom_bank_r  <= rom_bank_nxt;
      fg0_r       <= fg0_nxt;
      fg1_r       <= fg1_nxt;
      bg0_r       <= bg0_nxt;
      bg1_r       <= bg1_nxt;
    end
  end

  abd_cache #(
    .DEPTH (PALETTE_ENTRIES)
  ) u_cache (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (AW'(s0.pal_idx)),
    .rd_data (cache_rdata),
    .wr_en   (s1_adv && s1_r.pal_wr),
    .wr_addr (AW'(s1_r.pal_idx)),
    .wr_data (new_c),
    .busy    (cache_busy)
  );

  // Merge the written nibbles into the cached colour.
  always_comb begin
    base_c = fwd_r ? fwd_data_r : cache_rdata;
    if (s1_r.pal_odd) begin
      new_c = {base_c[23:16], s1_r.pal_data[3:0], s1_r.pal_data[3:0],
               s1_r.pal_data[7:4], s1_r.pal_data[7:4]};
    end else begin
      new_c = {s1_r.pal_data[3:0], s1_r.pal_data[3:0], base_c[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_v_r <= 1'b1;
        // The write-back of the item ahead lands at this same edge, after the read.
        fwd_r  <= s1_adv && s1_r.pal_wr && s0.pal_wr && (s1_r.pal_idx == s0.pal_idx);
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
        fwd_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r       <= s0;
      fwd_data_r <= new_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_data_r    <= s1_r.read_data;
      target_r       <= s1_r.target;
      maddr_r        <= s1_r.maddr;
      mwrite_r       <= s1_r.mwrite;
      dirty_layer_r  <= s1_r.dirty_layer;
      dirty_index_r  <= s1_r.dirty_index;
      pal_wr_r       <= s1_r.pal_wr;
      pal_idx_r      <= s1_r.pal_idx;
      pal_color_r    <= s1_r.pal_wr ? {ALPHA_OPAQUE, new_c} : '0;
      scroll_layer_r <= s1_r.scroll_layer;
      scroll_x_r     <= s1_r.scroll_x;
      irq_r          <= s1_r.irq;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = read_data_r;
  assign out_target         = target_r;
  assign out_memory_address = maddr_r;
  assign out_memory_write   = mwrite_r;
  assign out_dirty_layer    = dirty_layer_r;
  assign out_dirty_index    = dirty_index_r;
  assign out_palette_write  = pal_wr_r;
  assign out_palette_index  = pal_idx_r;
  assign out_palette_color  = pal_color_r;
  assign out_scroll_layer   = scroll_layer_r;
  assign out_scroll_x       = scroll_x_r;
  assign out_interrupt      = irq_r;

  `ASSERT_RST(a_clear_blocks_input, clk, rst_n, cache_busy |-> !in_accept, "transaction accepted during cache clear")
  `ASSERT_RST(a_stage_held, clk, rst_n, (s1_v_r && !s1_adv) |=> s1_v_r, "stalled transaction lost")
  `ASSERT_RST(a_fwd_palette, clk, rst_n, fwd_r |-> (s1_v_r && s1_r.pal_wr), "forward without cache write")
  `ASSERT_RST(a_pal_main, clk, rst_n, (out_valid_r && pal_wr_r) |-> (mwrite_r && target_r == TGT_MAIN), "palette write outside main RAM")

endmodule
`default_nettype wire

[rtl/abd_cache.sv]
// Colour cache memory of the bus decoder: one write and one registered read port.
// Clears itself after reset in one sweep; depends on abd_pkg.
`default_nettype none
module abd_cache #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        rd_en,
  input  wire [AW-1:0]               rd_addr,
  output logic [abd_pkg::COLOR_W-1:0] rd_data,
  input  wire                        wr_en,
  input  wire [AW-1:0]               wr_addr,
  input  wire [abd_pkg::COLOR_W-1:0] wr_data,
  output logic                       busy
);
  import abd_pkg::*;

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rd_data_r;
  logic               clr_busy_r;
  logic [AW-1:0]      clr_addr_r;
  logic               we;
  logic [AW-1:0]      wa;
  logic [COLOR_W-1:0] wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // The sweep owns the write port until every entry holds zero.
  always_comb begin
    we = clr_busy_r ? 1'b1 : wr_en;
    wa = clr_busy_r ? clr_addr_r : wr_addr;
    wd = clr_busy_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule
`default_nettype wire

[tb/sv/bus_decoder_monitor.sv]
// Watches the bus cycle, result and register ports of the bus decoder, predicts each
// result from its own model of the timer, decode and colour cache, and counts mismatches.
// Depends on abd_pkg for the mode, target, layer, register and address constants.
`timescale 1ns / 100ps
module bus_decoder_monitor #(
  parameter int PALETTE_ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [15:0]       in_address,
  input  logic [7:0]        in_write_data,
  input  logic [5:0]        in_tick_count,
  input  logic [7:0]        in_joystick_bits,
  input  logic [7:0]        in_button_bits,
  input  logic [7:0]        in_system_bits,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_read_data,
  input  logic [1:0]        out_target,
  input  logic [15:0]       out_memory_address,
  input  logic              out_memory_write,
  input  logic [1:0]        out_dirty_layer,
  input  logic [9:0]        out_dirty_index,
  input  logic              out_palette_write,
  input  logic [9:0]        out_palette_index,
  input  logic [31:0]       out_palette_color,
  input  logic [1:0]        out_scroll_layer,
  input  logic [16:0]       out_scroll_x,
  input  logic              out_interrupt,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [17:0]       cfg_data,
  output int unsigned       failures,
  output int unsigned       outstanding
);
  import abd_pkg::*;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  target;
    logic [15:0] memory_address;
    logic        memory_write;
    logic [1:0]  dirty_layer;
    logic [9:0]  dirty_index;
    logic        palette_write;
    logic [9:0]  palette_index;
    logic [31:0] palette_color;
    logic [1:0]  scroll_layer;
    logic [16:0] scroll_x;
    logic        interrupt;
  } bus_result_t;

  // Register copies.
  logic [17:0] period;
  logic [12:0] blank_len;
  logic [7:0]  bias;
  logic [7:0]  dip_high;

  // Timer and decode state. The counters are signed since both can overshoot below zero.
  int          frame_count;
  int          blank_count;
  logic [4:0]  bank;
  logic [7:0]  fg_pos_bytes [3];
  logic [7:0]  bg_pos_bytes [3];
  logic [23:0] shade_cache [PALETTE_ENTRIES];

  bus_result_t pending_results [$];
  int unsigned fail_count = 0;
  int unsigned result_count = 0;

  initial begin
    failures = 0;
    outstanding = 0;
  end

  function automatic void reset_model();
    period      = FRAME_PERIOD_RST;
    blank_len   = BLANK_LENGTH_RST;
    bias        = SCROLL_BIAS_RST;
    dip_high    = DIP_HIGH_RST;
    frame_count = int'(FRAME_PERIOD_RST);
    blank_count = 0;
    bank        = '0;
    for (int i = 0; i < 3; i++) begin
      fg_pos_bytes[i] = '0;
      bg_pos_bytes[i] = '0;
    end
    for (int i = 0; i < PALETTE_ENTRIES; i++) shade_cache[i] = '0;
  endfunction

  function automatic bus_result_t decode_cycle(
    logic [1:0] mode, logic [15:0] addr, logic [7:0] data, logic [5:0] ticks,
    logic [7:0] joy, logic [7:0] btn, logic [7:0] sys
  );
    bus_result_t r;
    logic [15:0] off;
    int          idx;
    logic [23:0] c;
    r = '0;

    // The frame timer runs on every accepted bus cycle, whatever the mode.
    frame_count -= int'(ticks);
    if (frame_count <= 0) begin
      frame_count += int'(period);
      if (frame_count < 0) frame_count = 0;
      blank_count = int'(blank_len);
    end
    if (blank_count > 0) begin
      blank_count -= int'(ticks);
      r.interrupt = 1'b1;
    end else begin
      blank_count = 0;
    end

    case (mode)
      MODE_WRITE: begin
        if (addr >= ADDR_RAM_LO && addr <= ADDR_MAIN_HI) begin
          r.target         = TGT_MAIN;
          r.memory_address = addr;
          r.memory_write   = 1'b1;
          if (addr >= ADDR_TXT_LO && addr <= ADDR_TXT_HI) begin
            r.dirty_layer = LYR_TEXT;
            r.dirty_index = 10'(addr - ADDR_TXT_LO);
          end else if (addr >= ADDR_FG_LO && addr <= ADDR_FG_HI) begin
            r.dirty_layer = LYR_FG;
            r.dirty_index = 10'(9'(addr - ADDR_FG_LO));
          end else if (addr >= ADDR_BG_LO && addr <= ADDR_BG_HI) begin
            r.dirty_layer = LYR_BG;
            r.dirty_index = 10'(9'(addr - ADDR_BG_LO));
          end else if (addr >= ADDR_PAL_LO) begin
            off = addr - ADDR_PAL_LO;
            idx = int'(off >> 1) % PALETTE_ENTRIES;
            c = shade_cache[idx];
            // Odd bytes carry green in the low nibble and red in the high one.
            if (off[0]) c = {c[23:16], data[3:0], data[3:0], data[7:4], data[7:4]};
            else c = {data[3:0], data[3:0], c[15:0]};
            shade_cache[idx] = c;
            r.palette_write = 1'b1;
            r.palette_index = 10'(idx);
            r.palette_color = {ALPHA_OPAQUE, c};
          end
        end else if (addr >= ADDR_FGS_LO && addr <= ADDR_FGS_HI) begin
          fg_pos_bytes[int'(addr - ADDR_FGS_LO)] = data;
          r.scroll_layer = SCR_FG;
          r.scroll_x = 17'({fg_pos_bytes[1], fg_pos_bytes[0]}) + 17'(bias);
        end else if (addr >= ADDR_BGS_LO && addr <= ADDR_BGS_HI) begin
          bg_pos_bytes[int'(addr - ADDR_BGS_LO)] = data;
          r.scroll_layer = SCR_BG;
          r.scroll_x = 17'({bg_pos_bytes[1], bg_pos_bytes[0]}) + 17'(bias);
        end else if (addr == ADDR_BANK) begin
          bank = data[7:3];
        end
      end
      MODE_READ: begin
        if (addr <= ADDR_MAIN_HI) begin
          r.target         = TGT_MAIN;
          r.memory_address = addr;
        end else if (addr >= ADDR_ROM_LO && addr <= ADDR_ROM_HI) begin
          r.target         = TGT_ROM;
          r.memory_address = addr - ADDR_ROM_LO + {bank, 11'd0};
        end else begin
          r.target = TGT_INT;
          if (addr == ADDR_JOY) r.read_data = joy;
          else if (addr == ADDR_BTN) r.read_data = btn;
          else if (addr == ADDR_SYS) r.read_data = sys;
          else if (addr == ADDR_DIP) r.read_data = dip_high;
        end
      end
      MODE_ACK: r.interrupt = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic string show_result(bus_result_t r);
    return $sformatf({"rd=%h tgt=%0d ma=%h mw=%b dl=%0d di=%h pw=%b pi=%h pc=%h",
                      " sl=%0d sx=%h irq=%b"},
                     r.read_data, r.target, r.memory_address, r.memory_write,
                     r.dirty_layer, r.dirty_index, r.palette_write, r.palette_index,
                     r.palette_color, r.scroll_layer, r.scroll_x, r.interrupt);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] MISMATCH %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    bus_result_t want;
    bus_result_t got;
    if (!rst_n) begin
      reset_model();
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_PERIOD: period    = cfg_data;
          CFG_BLANK_LENGTH: blank_len = cfg_data[12:0];
          CFG_SCROLL_BIAS:  bias      = cfg_data[7:0];
          CFG_DIP_HIGH:     dip_high  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_results.push_back(decode_cycle(in_mode, in_address, in_write_data,
                                               in_tick_count, in_joystick_bits,
                                               in_button_bits, in_system_bits));
      if (out_valid && !out_stall) begin
        got = {out_read_data, out_target, out_memory_address, out_memory_write,
               out_dirty_layer, out_dirty_index, out_palette_write, out_palette_index,
               out_palette_color, out_scroll_layer, out_scroll_x, out_interrupt};
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result %0d with nothing expected: %s",
                                 result_count, show_result(got)));
        end else begin
          want = pending_results.pop_front();
          if (got !== want)
            note_failure($sformatf("result %0d\n  expected %s\n  actual   %s",
                                   result_count, show_result(want), show_result(got)));
        end
        result_count++;
      end
    end
    failures    <= fail_count;
    outstanding <= pending_results.size();
  end

endmodule

[tb/sv/tb.sv]
// Top of the bus decoder testbench: clock, reset, bus cycle and register stimulus,
// result stall pattern and the final verdict. Depends on abd_pkg, the decoder RTL
// and bus_decoder_monitor, which does all prediction and checking.
`timescale 1ns / 100ps
module tb;
  import abd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic [5:0]  in_tick_count = '0;
  logic [7:0]  in_joystick_bits = '0;
  logic [7:0]  in_button_bits = '0;
  logic [7:0]  in_system_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic [1:0]  out_target;
  logic [15:0] out_memory_address;
  logic        out_memory_write;
  logic [1:0]  out_dirty_layer;
  logic [9:0]  out_dirty_index;
  logic        out_palette_write;
  logic [9:0]  out_palette_index;
  logic [31:0] out_palette_color;
  logic [1:0]  out_scroll_layer;
  logic [16:0] out_scroll_x;
  logic        out_interrupt;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned cycles = 0;
  int unsigned sent_count = 0;
  int          send_gap_pct = 20;
  int          recv_stall_pct = 10;
  bit          calm = 1'b0;

  arcade_board_bus_decoder u_dut (.*);
  bus_decoder_monitor u_monitor (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off to back the block up.
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && sent_count >= 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < recv_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one transaction and returns at the edge that accepts it, leaving valid high
  // unless a gap follows.
  task automatic send_cycle(input logic [1:0] mode, input logic [15:0] addr,
                            input logic [7:0] data, input logic [5:0] ticks);
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_address       <= addr;
    in_write_data    <= data;
    in_tick_count    <= ticks;
    in_joystick_bits <= 8'($urandom);
    in_button_bits   <= 8'($urandom);
    in_system_bits   <= 8'($urandom);
    do @(posedge clk); while (in_stall);
    sent_count++;
    if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic reg_write(input logic [1:0] idx, input logic [17:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Addresses lean toward the decoded regions; a small palette pool makes
  // back-to-back updates of the same colour entry common.
  function automatic logic [15:0] pick_address(bit is_write);
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return ADDR_RAM_LO + 16'($urandom_range(0, 16'h2fff));
      2: return ADDR_TXT_LO + 16'($urandom_range(0, 16'h0fff));
      3: return ADDR_PAL_LO + 16'($urandom_range(0, 15));
      4: return ADDR_PAL_LO + 16'($urandom_range(0, 16'h07ff));
      5: return ADDR_FGS_LO + 16'($urandom_range(0, 15));
      6: return ADDR_ROM_LO + 16'($urandom_range(0, 16'h07ff));
      default: return is_write ? ADDR_BANK : 16'($urandom_range(0, 16'hefff));
    endcase
  endfunction

  task automatic random_cycle();
    int         pick;
    logic [1:0] mode;
    pick = $urandom_range(0, 99);
    if (pick < 12) mode = MODE_IDLE;
    else if (pick < 25) mode = MODE_ACK;
    else if (pick < 55) mode = MODE_READ;
    else mode = MODE_WRITE;
    send_cycle(mode, pick_address(mode == MODE_WRITE), 8'($urandom), 6'($urandom));
  endtask

  task automatic set_registers(input int phase);
    logic [17:0] period;
    logic [12:0] blank_len;
    logic [7:0]  bias;
    logic [7:0]  dip_high;
    period    = 18'($urandom_range(1, 3000));
    blank_len = 13'($urandom_range(0, 2000));
    bias      = 8'($urandom);
    dip_high  = 8'($urandom);
    case (phase)
      0: begin
        period = 18'd1; blank_len = 13'd0; bias = 8'hff; dip_high = 8'h00;
      end
      1: begin
        period = 18'h3ffff; blank_len = 13'h1fff; bias = 8'h00; dip_high = 8'hff;
      end
      2: begin
        period = 18'd100; blank_len = 13'h1fff;
      end
      default: ;
    endcase
    reg_write(CFG_FRAME_PERIOD, period);
    reg_write(CFG_BLANK_LENGTH, 18'(blank_len));
    reg_write(CFG_SCROLL_BIAS, 18'(bias));
    reg_write(CFG_DIP_HIGH, 18'(dip_high));
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // The colour cache is cleared after reset while the input stalls.
    @(posedge clk);
    while (in_stall) @(posedge clk);

    // Directed cycles with the reset register values.
    send_cycle(MODE_IDLE,  16'h0000, 8'h00, 6'd0);
    send_cycle(MODE_IDLE,  16'hffff, 8'hff, 6'd63);
    send_cycle(MODE_ACK,   16'h0000, 8'h00, 6'd63);
    send_cycle(MODE_READ,  16'h0000, 8'h00, 6'd1);
    send_cycle(MODE_READ,  ADDR_MAIN_HI, 8'hff, 6'd2);
    send_cycle(MODE_READ,  ADDR_ROM_LO, 8'h00, 6'd3);
    send_cycle(MODE_WRITE, ADDR_BANK, 8'hff, 6'd4);
    send_cycle(MODE_READ,  ADDR_ROM_HI, 8'h00, 6'd5);
    send_cycle(MODE_READ,  ADDR_JOY, 8'h00, 6'd6);
    send_cycle(MODE_READ,  ADDR_BTN, 8'h00, 6'd7);
    send_cycle(MODE_READ,  ADDR_SYS, 8'h00, 6'd8);
    send_cycle(MODE_READ,  ADDR_DIP, 8'h00, 6'd9);
    send_cycle(MODE_READ,  16'hffff, 8'h00, 6'd10);
    send_cycle(MODE_WRITE, ADDR_RAM_LO, 8'h5a, 6'd11);
    send_cycle(MODE_WRITE, ADDR_TXT_HI, 8'ha5, 6'd12);
    send_cycle(MODE_WRITE, ADDR_FG_LO, 8'h01, 6'd13);
    send_cycle(MODE_WRITE, ADDR_BG_HI, 8'h80, 6'd14);
    send_cycle(MODE_WRITE, 16'he000, 8'h33, 6'd15);
    send_cycle(MODE_WRITE, ADDR_PAL_LO, 8'hff, 6'd16);
    send_cycle(MODE_WRITE, 16'hefff, 8'ha5, 6'd17);
    send_cycle(MODE_WRITE, ADDR_BTN, 8'hff, 6'd18);
    send_cycle(MODE_WRITE, ADDR_BGS_HI, 8'hff, 6'd19);
    send_cycle(MODE_WRITE, ADDR_FGS_HI, 8'h5a, 6'd20);
    send_cycle(MODE_WRITE, 16'h0000, 8'hff, 6'd21);
    send_cycle(MODE_WRITE, 16'hf806, 8'hff, 6'd22);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      set_registers(phase);
      send_gap_pct   = (phase % 3 == 1) ? 0 : 25;
      recv_stall_pct = (phase % 3 == 2) ? 0 : 15;
      calm           = (phase == 7);
      repeat (140) random_cycle();
    end

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
